>>> src/mbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
// No dependencies; imported by every module of the block.
`default_nettype none
package mbp_pkg;

  // Stream length limit and derived widths
  localparam int MAX_BYTES  = 4096;
  localparam int CNT_W      = $clog2(MAX_BYTES + 1);
  localparam int POS_W      = 12;
  localparam int VAL_W      = 32;
  localparam int CNT_IN_W   = 6;
  localparam int ACC_W      = VAL_W + 8;
  localparam int GRP_BYTES  = 4;
  localparam int NB_W       = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Operation codes
  localparam logic OP_PACK   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // One classified item: the bytes it completes, first emitted in slot 0
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] bytes;
    logic [NB_W-1:0]           nbytes;
    logic                      finish;
  } grp_t;

endpackage
`default_nettype wire

>>> src/mbp_front.sv
// Front end: accepts items, merges fields into the pending partial byte
// and forms byte groups. Depends on mbp_pkg.
`default_nettype none
module mbp_front
  import mbp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                in_operation,
  input  wire logic [VAL_W-1:0]    in_field_value,
  input  wire logic [CNT_IN_W-1:0] in_bit_count,
  output logic                     q_push,
  output grp_t                     q_entry,
  input  wire logic                q_full
);

  logic [6:0]          pend_bits_r, pend_bits_nxt;
  logic [2:0]          pend_cnt_r, pend_cnt_nxt;
  logic                accept;
  logic [CNT_IN_W-1:0] n_sat;
  logic [VAL_W:0]      mask_w;
  logic [VAL_W-1:0]    val_m;
  logic [ACC_W-1:0]    acc, aligned;
  logic [CNT_IN_W-1:0] total;
  logic [7:0]          fin_byte;
  grp_t                pack_grp, fin_grp;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Saturate the count and drop bits above it
  assign n_sat  = (in_bit_count > CNT_IN_W'(VAL_W)) ? CNT_IN_W'(VAL_W) : in_bit_count;
  assign mask_w = ~({(VAL_W+1){1'b1}} << n_sat);
  assign val_m  = in_field_value & mask_w[VAL_W-1:0];

  // Append to pending bits and left-align the complete bytes
  assign acc     = ({{(ACC_W-7){1'b0}}, pend_bits_r} << n_sat) | {8'b0, val_m};
  assign total   = {3'b0, pend_cnt_r} + n_sat;
  assign aligned = acc << (CNT_IN_W'(ACC_W) - total);

  always_comb begin
    for (int k = 0; k < GRP_BYTES; k++) begin
      pack_grp.bytes[k] = aligned[ACC_W-1-8*k -: 8];
    end
    pack_grp.nbytes = total[5:3];
    pack_grp.finish = 1'b0;
  end

  // Flush the partial byte padded with zeros
  assign fin_byte = 8'({1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r}));

  always_comb begin
    fin_grp.bytes    = '0;
    fin_grp.bytes[0] = fin_byte;
    fin_grp.nbytes   = (pend_cnt_r != 3'd0) ? NB_W'(1) : NB_W'(0);
    fin_grp.finish   = 1'b1;
  end

  // Select the group and next pending state; a pack that completes no byte
  // only updates the pending bits
  always_comb begin
    q_entry       = pack_grp;
    q_push        = 1'b0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (accept) begin
      unique case (in_operation)
        OP_FINISH: begin
          q_entry       = fin_grp;
          q_push        = 1'b1;
          pend_bits_nxt = '0;
          pend_cnt_nxt  = '0;
        end
        OP_PACK: begin
          q_push        = (pack_grp.nbytes != '0);
          pend_cnt_nxt  = total[2:0];
          pend_bits_nxt = acc[6:0] & ~(7'h7F << total[2:0]);
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  // Hold pending bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/mbp_queue.sv
// Short queue of byte groups between front and back end.
// Depends on mbp_pkg.
`default_nettype none
module mbp_queue
  import mbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  grp_t      wr_data,
  output logic      full,
  input  wire logic rd_en,
  output grp_t      rd_data,
  output logic      empty
);

  grp_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> src/mbp_back.sv
// Back end: walks each byte group, tracks stream position and overflow,
// and drives the registered result stage. Depends on mbp_pkg.
`default_nettype none
module mbp_back
  import mbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  grp_t             q_head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic [POS_W-1:0] out_byte_position,
  output logic             out_last_in_run,
  output logic             out_overflow
);

  logic [1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic [POS_W-1:0] opos_r, opos_nxt;
  logic             olast_r, olast_nxt;
  logic             oovf_r, oovf_nxt;
  logic             slot_free, bare_finish, emit, last, ovf;

  assign slot_free   = !ovalid_r || pop;
  assign bare_finish = !q_empty && (q_head.nbytes == '0);
  assign emit        = !q_empty && (q_head.nbytes != '0) && slot_free;
  assign last        = ({1'b0, idx_r} == q_head.nbytes - NB_W'(1));
  assign ovf         = (pos_r >= CNT_W'(MAX_BYTES));
  assign q_pop       = bare_finish || (emit && last);

  // Emit one byte per cycle from the head group while the result slot is free
  always_comb begin
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r && !pop;
    obyte_nxt  = obyte_r;
    opos_nxt   = opos_r;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;
    if (bare_finish) begin
      pos_nxt = '0;
    end else if (emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = ovf ? 8'd0 : q_head.bytes[idx_r];
      opos_nxt   = ovf ? '0 : POS_W'(pos_r);
      olast_nxt  = last;
      oovf_nxt   = ovf;
      idx_nxt    = last ? 2'd0 : idx_r + 2'd1;
      if (last && q_head.finish) begin
        pos_nxt = '0;
      end else if (!ovf) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign empty             = !ovalid_r;
  assign out_byte          = obyte_r;
  assign out_byte_position = opos_r;
  assign out_last_in_run   = olast_r;
  assign out_overflow      = oovf_r;

endmodule
`default_nettype wire

>>> src/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: front end, group queue, back end.
// Depends on mbp_pkg, mbp_front, mbp_queue and mbp_back.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------------
//  input   | push / full          | in_operation, in_field_value, in_bit_count
//  result  | pop / empty          | out_byte, out_byte_position, out_last_in_run,
//          |                      | out_overflow
//
// An item is taken in every cycle while the four-entry group queue has room.
// The back end emits one byte per cycle while its result stage is free or popped,
// walking each item's bytes (up to 4); that byte walk sets the sustained rate.
// Accepted items pass through the group queue, then the registered result stage.
// Reset is synchronous, active low; it empties the queue and result stage.
// A stalled pop holds the result stage and fills the queue, then full rises.
`default_nettype none
module msb_first_bit_packer
  import mbp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                in_operation,
  input  wire logic [VAL_W-1:0]    in_field_value,
  input  wire logic [CNT_IN_W-1:0] in_bit_count,
  output logic                     empty,
  input  wire logic                pop,
  output logic [7:0]               out_byte,
  output logic [POS_W-1:0]         out_byte_position,
  output logic                     out_last_in_run,
  output logic                     out_overflow
);

  grp_t q_wr_data, q_rd_data;
  logic q_wr, q_full, q_rd, q_empty;

  mbp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_field_value (in_field_value),
    .in_bit_count   (in_bit_count),
    .q_push         (q_wr),
    .q_entry        (q_wr_data),
    .q_full         (q_full)
  );

  mbp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  mbp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_rd_data),
    .q_empty           (q_empty),
    .q_pop             (q_rd),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_byte_position (out_byte_position),
    .out_last_in_run   (out_last_in_run),
    .out_overflow      (out_overflow)
  );

endmodule
`default_nettype wire

>>> src/mbp_checker.sv
// Port-level checks for the MSB-first bit packer, bound to the top level.
// Depends on mbp_pkg.
`default_nettype none
module mbp_checker
  import mbp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             full,
  input wire logic             empty,
  input wire logic             pop,
  input wire logic [7:0]       out_byte,
  input wire logic [POS_W-1:0] out_byte_position,
  input wire logic             out_last_in_run,
  input wire logic             out_overflow
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting after reset");

  // A dropped byte carries zero data and position
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_overflow) |-> (out_byte == 8'd0 && out_byte_position == '0))
    else $error("overflow byte with nonzero fields");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_byte_position)
                          && $stable(out_last_in_run) && $stable(out_overflow)))
    else $error("stalled result changed");

  // Reset leaves room for an item
  a_full_reset: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full after reset");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_byte          (out_byte),
  .out_byte_position (out_byte_position),
  .out_last_in_run   (out_last_in_run),
  .out_overflow      (out_overflow)
);
`default_nettype wire

>>> verif/msb_first_bit_packer_tb.sv
// Self-checking testbench for msb_first_bit_packer: directed fields and random streams,
// each byte checked against a local predictor.
// Depends on mbp_pkg and msb_first_bit_packer.
module msb_first_bit_packer_tb;
  import mbp_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                op;
    logic [VAL_W-1:0]    value;
    logic [CNT_IN_W-1:0] count;
  } field_item_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             ovf;
  } stream_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                in_operation = OP_PACK;
  logic [VAL_W-1:0]    in_field_value = '0;
  logic [CNT_IN_W-1:0] in_bit_count = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_byte;
  logic [POS_W-1:0]    out_byte_position;
  logic                out_last_in_run;
  logic                out_overflow;

  field_item_t  fields_to_send[$];
  stream_byte_t expected_bytes[$];

  // Predictor state: partial byte and position within the current stream
  logic [7:0]       part_bits = '0;
  logic [2:0]       part_cnt = '0;
  logic [CNT_W-1:0] stream_len = '0;

  int error_count = 0;
  int sent_count = 0;
  int taken_count = 0;
  int send_gap = 0;
  int pop_stall = 0;
  int stalled_cycles = 0;
  logic send_rush = 1'b0;
  logic take_rush = 1'b0;

  msb_first_bit_packer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_operation     (in_operation),
    .in_field_value   (in_field_value),
    .in_bit_count     (in_bit_count),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_byte_position(out_byte_position),
    .out_last_in_run  (out_last_in_run),
    .out_overflow     (out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Place one completed byte at the current stream position; past the limit it is dropped
  function automatic stream_byte_t place_byte(input logic [7:0] data);
    stream_byte_t rec;
    rec.last = 1'b0;
    if (stream_len >= MAX_BYTES) begin
      rec.data = '0;
      rec.pos  = '0;
      rec.ovf  = 1'b1;
    end else begin
      rec.data   = data;
      rec.pos    = stream_len[POS_W-1:0];
      rec.ovf    = 1'b0;
      stream_len = stream_len + 1'b1;
    end
    return rec;
  endfunction

  // Append one field (or finish the stream) and queue the bytes it completes
  function automatic void pack_into_stream(input logic op, input logic [VAL_W-1:0] value,
                                           input logic [CNT_IN_W-1:0] count);
    stream_byte_t fresh[GRP_BYTES];
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] mask;
    logic [ACC_W-1:0] sh;
    logic [7:0] padded;
    int n;
    int total;
    int made;
    made = 0;
    if (op == OP_FINISH) begin
      if (part_cnt != 0) begin
        padded = part_bits << (8 - part_cnt);
        fresh[0] = place_byte(padded);
        made = 1;
      end
      part_bits  = '0;
      part_cnt   = '0;
      stream_len = '0;
    end else begin
      n = (count > VAL_W) ? VAL_W : int'(count);
      if (n != 0) begin
        mask  = (ACC_W'(1) << n) - ACC_W'(1);
        acc   = (ACC_W'(part_bits) << n) | (ACC_W'(value) & mask);
        total = int'(part_cnt) + n;
        // Peel off whole bytes, oldest bits first
        while (total >= 8) begin
          sh = acc >> (total - 8);
          fresh[made] = place_byte(sh[7:0]);
          made++;
          total -= 8;
        end
        sh        = acc & ((ACC_W'(1) << total) - ACC_W'(1));
        part_bits = sh[7:0];
        part_cnt  = total[2:0];
      end
    end
    if (made > 0) begin
      fresh[made-1].last = 1'b1;
    end
    for (int i = 0; i < made; i++) begin
      expected_bytes.push_back(fresh[i]);
    end
  endfunction

  // Driver: predict on acceptance, then load the next field after its gap
  always @(posedge clk) begin
    field_item_t it;
    logic holding;
    holding = push;
    if (rst_n) begin
      if (push && !full) begin
        pack_into_stream(in_operation, in_field_value, in_bit_count);
        sent_count++;
        if (sent_count % 32 == 0) begin
          send_rush = ($urandom_range(0, 3) == 0);
        end
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (fields_to_send.size() != 0) begin
          it = fields_to_send.pop_front();
          in_operation   <= it.op;
          in_field_value <= it.value;
          in_bit_count   <= it.count;
          holding = 1'b1;
          send_gap <= send_rush ? 0 : $urandom_range(0, 6);
        end
      end
    end
    push <= holding;
  end

  // Monitor: check each popped byte against the oldest expectation, then stall at random
  always @(posedge clk) begin
    stream_byte_t want;
    logic ready;
    int s;
    ready = pop;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: out_byte %0h at position %0d", out_byte, out_byte_position);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
            error_count++;
          end
          if (out_byte_position !== want.pos) begin
            $error("out_byte_position: expected %0d, actual %0d", want.pos, out_byte_position);
            error_count++;
          end
          if (out_last_in_run !== want.last) begin
            $error("out_last_in_run: expected %0b, actual %0b", want.last, out_last_in_run);
            error_count++;
          end
          if (out_overflow !== want.ovf) begin
            $error("out_overflow: expected %0b, actual %0b", want.ovf, out_overflow);
            error_count++;
          end
        end
        taken_count++;
        if (taken_count % 32 == 0) begin
          take_rush = ($urandom_range(0, 3) == 0);
        end
        s = take_rush ? 0 : $urandom_range(0, 6);
        if (s != 0) begin
          ready = 1'b0;
          pop_stall <= s;
        end
      end else if (!pop) begin
        if (pop_stall > 1) begin
          pop_stall <= pop_stall - 1;
        end else begin
          pop_stall <= 0;
          ready = 1'b1;
        end
      end
    end
    pop <= ready;
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("msb_first_bit_packer_tb: done, errors");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  task automatic add_field(input logic op, input logic [VAL_W-1:0] value,
                           input logic [CNT_IN_W-1:0] count);
    field_item_t it;
    it.op    = op;
    it.value = value;
    it.count = count;
    fields_to_send.push_back(it);
  endtask

  initial begin
    logic [VAL_W-1:0] v;
    logic [CNT_IN_W-1:0] c;
    int pick;
    int n_items;

    // Directed: zero count, field extremes, masking, oversized counts, both finish cases
    add_field(OP_PACK, 32'hFFFF_FFFF, 6'd0);
    add_field(OP_PACK, 32'h0000_0001, 6'd1);
    add_field(OP_PACK, 32'h0000_007F, 6'd7);
    add_field(OP_PACK, 32'hFFFF_FFFF, 6'd32);
    add_field(OP_PACK, 32'h0000_0000, 6'd32);
    add_field(OP_PACK, 32'hFFFF_FFF5, 6'd3);
    add_field(OP_PACK, 32'hA5A5_A5A5, 6'd63);
    add_field(OP_PACK, 32'h1234_5678, 6'd33);
    add_field(OP_FINISH, 32'hFFFF_FFFF, 6'd63);
    add_field(OP_FINISH, 32'h0000_0000, 6'd0);
    add_field(OP_PACK, 32'h0000_0080, 6'd8);
    add_field(OP_PACK, 32'hFFFF_FFFF, 6'd5);
    add_field(OP_PACK, 32'h7FFF_FFFF, 6'd31);
    add_field(OP_PACK, 32'h8000_0001, 6'd32);
    add_field(OP_PACK, 32'h0000_0000, 6'd1);
    add_field(OP_FINISH, 32'h0000_0000, 6'd0);
    add_field(OP_PACK, 32'h5A5A_5A5A, 6'd16);
    add_field(OP_PACK, 32'hC3C3_C3C3, 6'd40);
    add_field(OP_PACK, 32'hFFFF_FFFF, 6'd0);
    add_field(OP_FINISH, 32'h0000_0000, 6'd0);

    // Random streams: mostly legal widths, some zero and oversized counts
    for (int i = 0; i < 204; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: v = '0;
        1: v = '1;
        default: v = $urandom;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        c = '0;
      end else if (pick == 1) begin
        c = CNT_IN_W'($urandom_range(33, 63));
      end else if (pick == 2) begin
        c = 6'd32;
      end else begin
        c = CNT_IN_W'($urandom_range(1, 32));
      end
      add_field(($urandom_range(0, 11) == 0) ? OP_FINISH : OP_PACK, v, c);
    end
    add_field(OP_FINISH, $urandom, CNT_IN_W'($urandom_range(0, 63)));

    // Close with a short stream and a padded final byte
    add_field(OP_PACK, $urandom, 6'd5);
    add_field(OP_PACK, $urandom, 6'd17);
    add_field(OP_FINISH, $urandom, 6'd0);
    add_field(OP_PACK, 32'h0000_00A5, 6'd8);
    add_field(OP_PACK, 32'h0000_0003, 6'd2);
    add_field(OP_FINISH, 32'h0000_0000, 6'd0);
    n_items = fields_to_send.size();

    // Hold reset, then release at a rising edge
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent, every byte back, then watch for strays
    while (sent_count < n_items || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("msb_first_bit_packer_tb: done, clean");
    end else begin
      $display("msb_first_bit_packer_tb: done, errors");
    end
    $finish;
  end

endmodule
